// ----- rtl/ihc_pkg.sv -----
package ihc_pkg;

  localparam int IB = 16;
  localparam int HB = 9;
  localparam int DW = IB + 6;
  localparam int AW = IB + 14;

  localparam logic [HB-1:0] HUE_RESET = 9'd280;
  localparam logic signed [IB-1:0] I_MAX = {1'b0, {(IB-1){1'b1}}};
  localparam logic signed [IB-1:0] I_MIN = {1'b1, {(IB-1){1'b0}}};

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_MEAS   = 2'd1;
  localparam logic [1:0] CMD_COLOUR = 2'd2;

  typedef struct packed {
    logic clr;
    logic meas;
    logic capture;
    logic prep;
    logic mul;
    logic div_step;
    logic set2;
    logic load_out;
  } ihc_cmd_t;

  typedef struct packed {
    logic empty;
    logic out_busy;
  } ihc_sts_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ihc_rgb_t;

  function automatic ihc_rgb_t rgb_map(input logic [3:0] q1, input logic [7:0] t);
    logic [3:0] s;
    logic [7:0] q;
    ihc_rgb_t c;
    s = (q1 >= 4'd6) ? (q1 - 4'd6) : q1;
    q = 8'd255 - t;
    unique case (s[2:0])
      3'd0: c = '{8'd255, t, 8'd0};
      3'd1: c = '{q, 8'd255, 8'd0};
      3'd2: c = '{8'd0, 8'd255, t};
      3'd3: c = '{8'd0, q, 8'd255};
      3'd4: c = '{t, 8'd0, 8'd255};
      default: c = '{8'd255, 8'd0, q};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ihc_if.sv -----
interface ihc_in_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic signed [ihc_pkg::IB-1:0] intensity;
  modport source (output valid, output cmd, output intensity, input ready);
  modport sink (input valid, input cmd, input intensity, output ready);
endinterface

interface ihc_out_if;
  logic valid;
  logic ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface ihc_cfg_if;
  logic valid;
  logic ready;
  logic [ihc_pkg::HB-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ihc_ctrl.sv -----
module ihc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_cmd,
  output logic             in_ready,
  input  ihc_pkg::ihc_sts_t sts,
  output ihc_pkg::ihc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_SET2 = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic [1:0] CMD_CLEAR_C  = ihc_pkg::CMD_CLEAR;
  localparam logic [1:0] CMD_MEAS_C   = ihc_pkg::CMD_MEAS;
  localparam logic [1:0] CMD_COLOUR_C = ihc_pkg::CMD_COLOUR;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_cmd)
            CMD_CLEAR_C: cmd.clr = 1'b1;
            CMD_MEAS_C: cmd.meas = 1'b1;
            CMD_COLOUR_C: begin
              cmd.capture = 1'b1;
              state_nxt = S_PREP;
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = 3'd3;
        state_nxt = sts.empty ? S_OUT : S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          state_nxt = S_SET2;
        end
      end
      S_SET2: begin
        cmd.set2 = 1'b1;
        cnt_nxt = 3'd7;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/ihc_dp.sv -----
module ihc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ihc_pkg::ihc_cmd_t              cmd,
  output ihc_pkg::ihc_sts_t              sts,
  input  logic signed [ihc_pkg::IB-1:0]  intensity,
  input  logic                           cfg_valid,
  input  logic [ihc_pkg::HB-1:0]         cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output ihc_pkg::ihc_rgb_t              out_rgb
);

  localparam int IB = ihc_pkg::IB;
  localparam int HB = ihc_pkg::HB;
  localparam int DW = ihc_pkg::DW;
  localparam int AW = ihc_pkg::AW;

  logic signed [IB-1:0] low_r, high_r, x_r, xc;
  logic [HB-1:0]        hue_r;
  logic [IB-1:0]        diff_r, span_r;
  logic                 empty_r;
  logic [AW-1:0]        acc_r, dsh_r, prod, sub;
  logic [DW-1:0]        den_r, den_w;
  logic [7:0]           q_r;
  logic [3:0]           q1_r;
  logic                 out_valid_r, ge;
  ihc_pkg::ihc_rgb_t    rgb_r;
  logic signed [IB:0]   diff_w, span_w;

  always_comb begin
    if (x_r < low_r) begin
      xc = low_r;
    end else if (x_r > high_r) begin
      xc = high_r;
    end else begin
      xc = x_r;
    end
  end

  assign diff_w = {high_r[IB-1], high_r} - {xc[IB-1], xc};
  assign span_w = {high_r[IB-1], high_r} - {low_r[IB-1], low_r};
  assign den_w  = {span_r, 6'd0} - {4'd0, span_r, 2'd0};
  assign prod   = {{(AW-IB){1'b0}}, diff_r} * {{(AW-HB){1'b0}}, hue_r};
  assign ge     = (acc_r >= dsh_r);
  assign sub    = acc_r - dsh_r;

  assign sts.empty    = empty_r;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_rgb      = rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r <= ihc_pkg::HUE_RESET;
      low_r <= ihc_pkg::I_MAX;
      high_r <= ihc_pkg::I_MIN;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        hue_r <= cfg_data;
      end
      if (cmd.clr) begin
        low_r <= ihc_pkg::I_MAX;
        high_r <= ihc_pkg::I_MIN;
      end else if (cmd.meas) begin
        if (intensity < low_r) begin
          low_r <= intensity;
        end
        if (intensity > high_r) begin
          high_r <= intensity;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= intensity;
    end
    if (cmd.prep) begin
      diff_r <= diff_w[IB-1:0];
      span_r <= span_w[IB-1:0];
      empty_r <= (high_r <= low_r);
    end
    if (cmd.mul) begin
      acc_r <= prod;
      den_r <= den_w;
      dsh_r <= {{(AW-DW-3){1'b0}}, den_w, 3'd0};
      q_r <= 8'd0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        acc_r <= sub;
      end
      dsh_r <= {1'b0, dsh_r[AW-1:1]};
      q_r <= {q_r[6:0], ge};
    end
    if (cmd.set2) begin
      q1_r <= q_r[3:0];
      q_r <= 8'd0;
      acc_r <= {acc_r[AW-9:0], 8'd0} - acc_r + {{(AW-DW+1){1'b0}}, den_r[DW-1:1]};
      dsh_r <= {{(AW-DW-7){1'b0}}, den_r, 7'd0};
    end
    if (cmd.load_out) begin
      if (empty_r) begin
        rgb_r <= '{8'd255, 8'd0, 8'd0};
      end else begin
        rgb_r <= ihc_pkg::rgb_map(q1_r, q_r);
      end
    end
  end

endmodule

// ----- rtl/intensity_to_hue_colour_core.sv -----
// channel   dir  payload                       handshake
// in_ch     in   cmd[1:0], intensity[15:0] s   valid/ready
// out_ch    out  red[7:0], green[7:0], blue[7:0] valid/ready
// cfg_ch    in   data[8:0] (hue_range)          valid/ready, always ready
//
// clear and measure finish in the accept cycle; a colour request runs from accept
// to result through clamp, multiply, 4 quotient steps for the sector and
// 8 steps for the channel level on one shared compare-subtract unit.
// empty range skips the division.
// reset (rst_n low, synchronous) sets hue_range to 280 and clears the range.
// a waiting result holds in the output register; the next request is taken
// meanwhile and stalls only at its own output load.
module intensity_to_hue_colour_core (
  input logic clk,
  input logic rst_n,
  ihc_in_if.sink    in_ch,
  ihc_out_if.source out_ch,
  ihc_cfg_if.sink   cfg_ch
);

  ihc_pkg::ihc_cmd_t cmd;
  ihc_pkg::ihc_sts_t sts;
  ihc_pkg::ihc_rgb_t rgb;

  assign cfg_ch.ready = 1'b1;

  ihc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ihc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .intensity (in_ch.intensity),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_rgb   (rgb)
  );

  assign out_ch.red   = rgb.red;
  assign out_ch.green = rgb.green;
  assign out_ch.blue  = rgb.blue;

`ifndef NO_ASSERTIONS
  a_rise_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("result appeared without an output load");

  a_empty_red: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && sts.empty) |=>
      (out_ch.red == 8'd255 && out_ch.green == 8'd0 && out_ch.blue == 8'd0))
    else $error("empty range did not give red");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.mul || cmd.set2) |-> !in_ch.ready)
    else $error("request taken while colour in progress");

  a_full_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.red == 8'd255 || out_ch.green == 8'd255 ||
                      out_ch.blue == 8'd255))
    else $error("colour without a full channel");
`endif

endmodule
